// File: design/mcl_pkg.sv
// ----------------------------------------------------------------------------
// mcl_pkg
// Types, constants and the key loading function for the majority clocked
// three-register stream cipher.
// ----------------------------------------------------------------------------
package mcl_pkg;

  localparam int unsigned LEN_ONE     = 19;
  localparam int unsigned LEN_TWO     = 22;
  localparam int unsigned LEN_THREE   = 23;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned FRAME_W     = 22;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned BYTE_CLOCKS = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  // majority clock bit positions
  localparam int unsigned CLK_ONE   = 8;
  localparam int unsigned CLK_TWO   = 10;
  localparam int unsigned CLK_THREE = 10;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } mcl_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY   = 1'b0,
    CFG_FRAME = 1'b1
  } mcl_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_BYTE,
    ST_HOLD
  } mcl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } mcl_bank_ctl_t;

  // key bit i lands on bit len-1 - (i mod len), later bits win;
  // frame bits are then xored in on the same mapping
  function automatic logic [LEN_THREE-1:0] load_reg(input logic [KEY_W-1:0]   key,
                                                    input logic [FRAME_W-1:0] frame,
                                                    input int unsigned        len);
    logic [LEN_THREE-1:0] r;
    int unsigned          pos;
    r   = '0;
    pos = len - 1;
    for (int unsigned i = 0; i < KEY_W; i++) begin
      r[pos] = key[i];
      pos    = (pos == 0) ? len - 1 : pos - 1;
    end
    pos = len - 1;
    for (int unsigned i = 0; i < FRAME_W; i++) begin
      r[pos] = r[pos] ^ frame[i];
      pos    = (pos == 0) ? len - 1 : pos - 1;
    end
    return r;
  endfunction

endpackage

// File: design/mcl_if.sv
// ----------------------------------------------------------------------------
// mcl channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface mcl_in_if
  import mcl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [DATA_W-1:0]   data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface mcl_out_if
  import mcl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

interface mcl_cfg_if
  import mcl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [KEY_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/mcl_lfsr_bank.sv
// ----------------------------------------------------------------------------
// mcl_lfsr_bank
// The three shift registers with load and one majority clock per cycle while stepped.
// ----------------------------------------------------------------------------
module mcl_lfsr_bank
  import mcl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcl_bank_ctl_t        ctl_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [FRAME_W-1:0]   frame_i,
  output logic                 ks_bit_o
);

  logic [LEN_ONE-1:0]   r1_q, r1_d, s1;
  logic [LEN_TWO-1:0]   r2_q, r2_d, s2;
  logic [LEN_THREE-1:0] r3_q, r3_d, s3;
  logic [LEN_THREE-1:0] ld1, ld2, ld3;
  logic                 a, b, c, maj;

  assign a   = r1_q[CLK_ONE];
  assign b   = r2_q[CLK_TWO];
  assign c   = r3_q[CLK_THREE];
  assign maj = (a & b) | (a & c) | (b & c);

  // one majority clock: shift toward bit 0, feedback into the top
  always_comb begin
    s1 = r1_q;
    s2 = r2_q;
    s3 = r3_q;
    if (a == maj) begin
      s1 = {r1_q[13] ^ r1_q[16] ^ r1_q[17] ^ r1_q[18], r1_q[LEN_ONE-1:1]};
    end
    if (b == maj) begin
      s2 = {r2_q[20] ^ r2_q[21], r2_q[LEN_TWO-1:1]};
    end
    if (c == maj) begin
      s3 = {r3_q[7] ^ r3_q[20] ^ r3_q[21] ^ r3_q[22], r3_q[LEN_THREE-1:1]};
    end
  end

  assign ld1 = load_reg(key_i, frame_i, LEN_ONE);
  assign ld2 = load_reg(key_i, frame_i, LEN_TWO);
  assign ld3 = load_reg(key_i, frame_i, LEN_THREE);

  always_comb begin
    r1_d = r1_q;
    r2_d = r2_q;
    r3_d = r3_q;
    if (ctl_i.load) begin
      r1_d = ld1[LEN_ONE-1:0];
      r2_d = ld2[LEN_TWO-1:0];
      r3_d = ld3;
    end else if (ctl_i.step) begin
      r1_d = s1;
      r2_d = s2;
      r3_d = s3;
    end
  end

  // keystream bit of the clock taken this cycle
  assign ks_bit_o = s1[LEN_ONE-1] ^ s2[LEN_TWO-1] ^ s3[LEN_THREE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= '0;
      r2_q <= '0;
      r3_q <= '0;
    end else begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
    end
  end

endmodule

// File: design/mcl_ctrl.sv
// ----------------------------------------------------------------------------
// mcl_ctrl
// Sequencer: warm-up and byte clock counts, keystream collection and the
// result register.
// ----------------------------------------------------------------------------
module mcl_ctrl
  import mcl_pkg::*;
#(
  parameter int unsigned WarmupClocks = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_operation_i,
  input  logic [DATA_W-1:0]   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   out_data_o,
  output mcl_bank_ctl_t       ctl_o,
  input  logic                ks_bit_i
);

  localparam int unsigned CntMax = (WarmupClocks > BYTE_CLOCKS) ? WarmupClocks : BYTE_CLOCKS;
  localparam int unsigned CntW   = $clog2(CntMax);

  mcl_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0]   ks_q, ks_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;
  logic                out_valid_q, out_valid_d;
  logic                accept, is_start, last, slot_free, out_load;
  logic [DATA_W-1:0]   ks_shift;

  assign accept    = in_valid_i && in_ready_o;
  assign is_start  = (mcl_op_e'(in_operation_i) == OP_START);
  assign last      = (cnt_q == '0);
  assign slot_free = !out_valid_q || out_ready_i;
  assign ks_shift  = {ks_bit_i, ks_q[DATA_W-1:1]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_start) begin
            state_d = ST_BYTE;
          end else if (WarmupClocks != 0) begin
            state_d = ST_WARM;
          end
        end
      end
      ST_WARM: begin
        if (last) state_d = ST_IDLE;
      end
      ST_BYTE: begin
        if (last) state_d = slot_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    ctl_o      = '0;
    out_load   = 1'b0;
    out_data_d = out_data_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i && is_start;
      end
      ST_WARM: begin
        ctl_o.step = 1'b1;
      end
      ST_BYTE: begin
        ctl_o.step = 1'b1;
        out_load   = last && slot_free;
        out_data_d = data_q ^ ks_shift;
      end
      ST_HOLD: begin
        out_load   = slot_free;
        out_data_d = data_q ^ ks_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    ks_d   = ks_q;
    data_d = data_q;
    if (accept) begin
      data_d = in_data_i;
      cnt_d  = is_start ? CntW'(WarmupClocks - 1) : CntW'(BYTE_CLOCKS - 1);
    end else if (ctl_o.step && !last) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (state_q == ST_BYTE) begin
      ks_d = ks_shift;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q       <= ks_d;
    data_q     <= data_d;
    if (out_load) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result only ever comes out of byte processing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_BYTE || $past(state_q) == ST_HOLD))
    else $error("result without a byte in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BYTE |-> cnt_q <= CntW'(BYTE_CLOCKS - 1))
    else $error("byte clock count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("holding a result with a free output slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> !ctl_o.step && state_q == ST_IDLE)
    else $error("register load outside idle");

endmodule

// File: design/majority_clocked_lfsr_stream_cipher.sv
// ----------------------------------------------------------------------------
// majority_clocked_lfsr_stream_cipher
// Three majority clocked shift registers; start items load key and frame and
// warm up, byte items are xored with eight keystream bits.
// ----------------------------------------------------------------------------
// byte item: one register clock per keystream bit, result registered after the last
//   one, next item accepted once the result is registered (later if the result waits)
// start item: load on acceptance, then busy with the warm-up clocks, no result
// one majority clock per cycle in the shared register bank while warming up or on a byte
// reset clears the registers, key and frame to zero and empties the output
// ----------------------------------------------------------------------------
module majority_clocked_lfsr_stream_cipher
  import mcl_pkg::*;
#(
  parameter int unsigned WARMUP_CLOCKS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcl_in_if.sink      in_i,
  mcl_out_if.source   out_o,
  mcl_cfg_if.sink     cfg_i
);

  logic [KEY_W-1:0]   key_q, key_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  mcl_bank_ctl_t      bank_ctl;
  logic               ks_bit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_d   = key_q;
    frame_d = frame_q;
    if (cfg_i.valid) begin
      case (mcl_cfg_e'(cfg_i.index))
        CFG_KEY:   key_d   = cfg_i.data;
        CFG_FRAME: frame_d = cfg_i.data[FRAME_W-1:0];
        default:   key_d   = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      frame_q <= '0;
    end else begin
      key_q   <= key_d;
      frame_q <= frame_d;
    end
  end

  mcl_ctrl #(
    .WarmupClocks (WARMUP_CLOCKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_operation_i (in_i.operation),
    .in_data_i      (in_i.data_byte),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_data_o     (out_o.result_byte),
    .ctl_o          (bank_ctl),
    .ks_bit_i       (ks_bit)
  );

  mcl_lfsr_bank u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (bank_ctl),
    .key_i    (key_q),
    .frame_i  (frame_q),
    .ks_bit_o (ks_bit)
  );

endmodule

// File: dv/mcl_cipher_checker.sv
// ----------------------------------------------------------------------------
// mcl_cipher_checker
// Watches the item, result and register channels of the cipher, keeps its
// own copy of the three shift registers, key and frame, predicts every
// result byte and compares it with what the block returns.
// ----------------------------------------------------------------------------
module mcl_cipher_checker
  import mcl_pkg::*;
#(
  parameter int unsigned WARMUP_CLOCKS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcl_in_if           in_mon,
  mcl_out_if          out_mon,
  mcl_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  bit [LEN_ONE-1:0]   sr19;
  bit [LEN_TWO-1:0]   sr22;
  bit [LEN_THREE-1:0] sr23;
  bit [KEY_W-1:0]     key_q;
  bit [FRAME_W-1:0]   frame_q;

  logic [DATA_W-1:0]  expected_bytes_q[$];

  // one majority step: registers that agree with the majority shift down
  function automatic void step_registers();
    bit a, b, c, maj, fb;
    a   = sr19[CLK_ONE];
    b   = sr22[CLK_TWO];
    c   = sr23[CLK_THREE];
    maj = (a & b) | (a & c) | (b & c);
    if (a == maj) begin
      fb   = sr19[13] ^ sr19[16] ^ sr19[17] ^ sr19[18];
      sr19 = {fb, sr19[LEN_ONE-1:1]};
    end
    if (b == maj) begin
      fb   = sr22[20] ^ sr22[21];
      sr22 = {fb, sr22[LEN_TWO-1:1]};
    end
    if (c == maj) begin
      fb   = sr23[7] ^ sr23[20] ^ sr23[21] ^ sr23[22];
      sr23 = {fb, sr23[LEN_THREE-1:1]};
    end
  endfunction

  function automatic void load_and_warm_up();
    for (int i = 0; i < KEY_W; i++) begin
      sr19[LEN_ONE-1 - (i % LEN_ONE)]     = key_q[i];
      sr22[LEN_TWO-1 - (i % LEN_TWO)]     = key_q[i];
      sr23[LEN_THREE-1 - (i % LEN_THREE)] = key_q[i];
    end
    for (int i = 0; i < FRAME_W; i++) begin
      sr19[LEN_ONE-1 - (i % LEN_ONE)]     ^= frame_q[i];
      sr22[LEN_TWO-1 - (i % LEN_TWO)]     ^= frame_q[i];
      sr23[LEN_THREE-1 - (i % LEN_THREE)] ^= frame_q[i];
    end
    for (int n = 0; n < WARMUP_CLOCKS; n++) begin
      step_registers();
    end
  endfunction

  // keystream bit i comes from the i-th step, lsb first
  function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] ks;
    for (int i = 0; i < BYTE_CLOCKS; i++) begin
      step_registers();
      ks[i] = sr19[LEN_ONE-1] ^ sr22[LEN_TWO-1] ^ sr23[LEN_THREE-1];
    end
    return d ^ ks;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DATA_W-1:0] want;
    if (!rst_ni) begin
      sr19    = '0;
      sr22    = '0;
      sr23    = '0;
      key_q   = '0;
      frame_q = '0;
      expected_bytes_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_KEY: begin
            key_q = cfg_mon.data;
          end
          CFG_FRAME: begin
            frame_q = cfg_mon.data[FRAME_W-1:0];
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %02h",
                   $time, out_mon.result_byte);
          fail_count_o++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_mon.result_byte !== want) begin
            $display("%0t: result_byte mismatch: expected %02h, got %02h",
                     $time, want, out_mon.result_byte);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_BYTE) begin
          expected_bytes_q.push_back(cipher_byte(in_mon.data_byte));
        end else begin
          load_and_warm_up();
        end
      end
    end
    pending_o = expected_bytes_q.size();
  end

endmodule

// File: dv/tb_majority_clocked_lfsr_stream_cipher.sv
// ----------------------------------------------------------------------------
// tb_majority_clocked_lfsr_stream_cipher
// Drives start and byte items and register writes into the cipher under
// several idling patterns; the checker beside the block predicts and
// compares every result byte, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_majority_clocked_lfsr_stream_cipher;
  import mcl_pkg::*;

  localparam int unsigned WARMUP        = 100;
  localparam int unsigned SETTLE_CYCLES = WARMUP + 20;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 118;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned pending_bytes;
  int unsigned quiet_cycles;

  mcl_in_if  in_ch ();
  mcl_out_if out_ch ();
  mcl_cfg_if cfg_ch ();

  majority_clocked_lfsr_stream_cipher #(
    .WARMUP_CLOCKS (WARMUP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  mcl_cipher_checker #(
    .WARMUP_CLOCKS (WARMUP)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 61;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 61;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input mcl_op_e op, input logic [DATA_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= mcl_op_e'($urandom_range(0, 1));
      in_ch.data_byte <= DATA_W'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
  endtask

  // a start item leaves the block busy with no result outstanding
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] frame_word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_KEY;
    cfg_ch.data  <= key;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.index <= CFG_FRAME;
    cfg_ch.data  <= frame_word;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] frame_word;
    mcl_op_e          op;

    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_START;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_KEY;
    cfg_ch.data     = '0;
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bytes before any start pass through unchanged
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hA5);

    settle_block();
    write_regs('1, '1);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h80);
    // restart back to back, data on a start is ignored
    send_item(OP_START, 8'hFF);
    send_item(OP_START, 8'h3C);
    send_item(OP_BYTE, 8'h7E);
    send_item(OP_BYTE, 8'hC3);

    // all-zero registers never move off zero, upper data bits ignored for frame
    settle_block();
    write_regs('0, 64'hFFFF_FFFF_FFC0_0000);
    send_item(OP_START, 8'h5A);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h55);

    settle_block();
    write_regs(64'h0123_4567_89AB_CDEF, 64'h1);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h12);
    send_item(OP_BYTE, 8'h34);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle_block();
      key        = {$urandom(), $urandom()};
      frame_word = {$urandom(), $urandom()};
      if (phase == 4) begin
        key        = '0;
        frame_word = '1;
      end else if (phase == 6) begin
        key        = '1;
        frame_word = '0;
      end
      write_regs(key, frame_word);
      set_idling(idle_mode_e'(phase % 4));
      // one phase carries on from the previous key stream without a start
      if (phase != 5) begin
        send_item(OP_START, DATA_W'($urandom_range(0, 255)));
      end
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        op = ($urandom_range(0, 19) == 0) ? OP_START : OP_BYTE;
        send_item(op, DATA_W'($urandom_range(0, 255)));
      end
    end

    settle_block();
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
